@@ rtl/rtph264_pkg.sv @@
// Shared types and constants for the RTP H.264 packetiser.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rtph264_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_PAYLOAD_TYPE   = 2'd0;
  localparam logic [1:0] REG_SSRC           = 2'd1;
  localparam logic [1:0] REG_START_SEQUENCE = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD    = 2'd3;

  localparam logic [6:0]  PAYLOAD_TYPE_RESET = 7'd96;
  localparam logic [31:0] SSRC_RESET         = 32'd0;
  localparam logic [15:0] START_SEQ_RESET    = 16'd0;
  localparam logic [13:0] MAX_PAYLOAD_RESET  = 14'd1400;
  localparam logic [13:0] CAP_MIN            = 14'd16;
  localparam logic [13:0] CAP_MAX            = 14'd8192;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] FU_A_TYPE        = 8'd28;
  localparam logic [7:0] FU_START_BIT     = 8'h80;
  localparam logic [7:0] FU_END_BIT       = 8'h40;
  localparam logic [7:0] NRI_MASK         = 8'h60;
  localparam logic [7:0] TYPE_MASK        = 8'h1f;

  // Output step numbers within one job.
  localparam logic [3:0] STEP_DATA_ONLY = 4'd0;
  localparam logic [3:0] STEP_FU_IND    = 4'd12;
  localparam logic [3:0] STEP_FU_HDR    = 4'd13;
  localparam logic [3:0] STEP_LAST_RTP  = 4'd12;
  localparam logic [3:0] STEP_LAST_FU   = 4'd14;

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_RTP,
    HDR_FU
  } hdr_kind_t;

  // One classified input beat, ready for the back end to serialise.
  typedef struct packed {
    logic [7:0]  data;
    logic        data_end;
    hdr_kind_t   hdr;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
  } job_t;

endpackage

@@ rtl/rtph264_front.sv @@
// Front end of the packetiser: accepts NAL bytes, tracks NAL and fragment
// position and the sequence number, and queues one job per producing beat.
// Depends on rtph264_pkg.
module rtph264_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          nal_byte,
  input  logic [15:0]         nal_length,
  input  logic [31:0]         timestamp,
  input  logic [13:0]         max_payload,
  input  logic                seq_load,
  input  logic [15:0]         seq_load_value,
  input  logic                queue_full,
  output logic                push,
  output rtph264_pkg::job_t   job
);
  import rtph264_pkg::*;

  logic [15:0] sequence_counter;
  logic [15:0] nal_position;
  logic [15:0] fragment_remaining;
  logic [7:0]  saved_nal_header;
  logic        fragmenting_mode;

  logic [15:0] sequence_counter_next;
  logic [15:0] nal_position_next;
  logic [15:0] fragment_remaining_next;
  logic [7:0]  saved_nal_header_next;
  logic        fragmenting_mode_next;

  logic        accept;
  logic [13:0] cap;
  logic        nal_end;
  logic        pos_zero;
  logic        first;
  logic [15:0] limit;
  logic [15:0] avail;
  logic [15:0] count;
  logic        last;
  logic [15:0] rem_after;
  logic [7:0]  flags;
  logic        produce;

  assign in_ready = !queue_full && !rst;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (max_payload < CAP_MIN) begin
      cap = CAP_MIN;
    end else if (max_payload > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = max_payload;
    end
  end

  assign nal_end  = ({1'b0, nal_position} + 17'd1) >= {1'b0, nal_length};
  assign pos_zero = (nal_position == 16'd0);
  assign first    = (nal_position == 16'd1);
  assign limit    = first ? {2'b00, cap - 14'd1} : {2'b00, cap};
  assign avail    = (nal_length > nal_position) ? (nal_length - nal_position) : 16'd1;
  assign count    = (avail < limit) ? avail : limit;
  assign last     = ({1'b0, nal_position} + {1'b0, count}) >= {1'b0, nal_length};
  assign flags    = first ? FU_START_BIT : (last ? FU_END_BIT : 8'h00);

  always_comb begin
    fragmenting_mode_next   = pos_zero ? (nal_length > {2'b00, cap}) : fragmenting_mode;
    saved_nal_header_next   = saved_nal_header;
    fragment_remaining_next = fragment_remaining;
    sequence_counter_next   = sequence_counter;
    produce                 = 1'b1;
    rem_after               = 16'd0;

    job.data   = nal_byte;
    job.data_end = nal_end;
    job.hdr    = HDR_NONE;
    job.marker = 1'b1;
    job.seq    = sequence_counter;
    job.ts     = timestamp;
    job.fu_ind = (saved_nal_header & NRI_MASK) | FU_A_TYPE;
    job.fu_hdr = flags | (saved_nal_header & TYPE_MASK);

    if (!fragmenting_mode_next) begin
      if (pos_zero) begin
        job.hdr               = HDR_RTP;
        sequence_counter_next = sequence_counter + 16'd1;
      end
    end else if (pos_zero) begin
      // The original NAL header is only kept for the FU indicator and header.
      saved_nal_header_next = nal_byte;
      produce               = 1'b0;
    end else begin
      if (fragment_remaining == 16'd0) begin
        job.hdr               = HDR_FU;
        job.marker            = last;
        sequence_counter_next = sequence_counter + 16'd1;
        rem_after             = count - 16'd1;
      end else begin
        rem_after = fragment_remaining - 16'd1;
      end
      if (nal_end) begin
        rem_after = 16'd0;
      end
      fragment_remaining_next = rem_after;
      job.data_end            = (rem_after == 16'd0) || nal_end;
    end

    nal_position_next = nal_end ? 16'd0 : nal_position + 16'd1;
  end

  assign push = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter   <= START_SEQ_RESET;
      nal_position       <= 16'd0;
      fragment_remaining <= 16'd0;
      saved_nal_header   <= 8'd0;
      fragmenting_mode   <= 1'b0;
    end else begin
      if (seq_load) begin
        sequence_counter <= seq_load_value;
      end else if (accept) begin
        sequence_counter <= sequence_counter_next;
      end
      if (accept) begin
        nal_position       <= nal_position_next;
        fragment_remaining <= fragment_remaining_next;
        saved_nal_header   <= saved_nal_header_next;
        fragmenting_mode   <= fragmenting_mode_next;
      end
    end
  end

endmodule

@@ rtl/rtph264_queue.sv @@
// Short job queue between the front and back ends of the packetiser.
// Depends on rtph264_pkg.
module rtph264_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rtph264_pkg::job_t push_job,
  output logic              full,
  output logic              head_valid,
  output rtph264_pkg::job_t head_job,
  input  logic              pop
);
  import rtph264_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full       = (fill == CntFull);
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/rtph264_back.sv @@
// Back end of the packetiser: serialises each queued job into its RTP
// header and FU bytes, if any, and its data byte, into an output register,
// one beat per cycle unless out_ready stalls it. Depends on rtph264_pkg.
module rtph264_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  rtph264_pkg::job_t head_job,
  output logic              pop,
  input  logic [6:0]        rtp_pt,
  input  logic [31:0]       stream_source_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        packet_byte,
  output logic              packet_end,
  output logic              run_last
);
  import rtph264_pkg::*;

  logic [3:0] step;
  logic [3:0] last_step;
  logic       advance;
  logic       at_last;
  logic [7:0] byte_sel;
  logic [7:0] hdr_byte;

  always_comb begin
    case (head_job.hdr)
      HDR_NONE: last_step = STEP_DATA_ONLY;
      HDR_RTP:  last_step = STEP_LAST_RTP;
      HDR_FU:   last_step = STEP_LAST_FU;
      default:  last_step = STEP_DATA_ONLY;
    endcase
  end

  always_comb begin
    case (step)
      4'd0:    hdr_byte = RTP_VERSION_BYTE;
      4'd1:    hdr_byte = {head_job.marker, rtp_pt};
      4'd2:    hdr_byte = head_job.seq[15:8];
      4'd3:    hdr_byte = head_job.seq[7:0];
      4'd4:    hdr_byte = head_job.ts[31:24];
      4'd5:    hdr_byte = head_job.ts[23:16];
      4'd6:    hdr_byte = head_job.ts[15:8];
      4'd7:    hdr_byte = head_job.ts[7:0];
      4'd8:    hdr_byte = stream_source_id[31:24];
      4'd9:    hdr_byte = stream_source_id[23:16];
      4'd10:   hdr_byte = stream_source_id[15:8];
      4'd11:   hdr_byte = stream_source_id[7:0];
      default: hdr_byte = RTP_VERSION_BYTE;
    endcase
  end

  assign at_last = (step == last_step);

  always_comb begin
    if (at_last) begin
      byte_sel = head_job.data;
    end else if (step == STEP_FU_IND) begin
      byte_sel = head_job.fu_ind;
    end else if (step == STEP_FU_HDR) begin
      byte_sel = head_job.fu_hdr;
    end else begin
      byte_sel = hdr_byte;
    end
  end

  // The output register frees up in the same cycle that it is taken.
  assign advance = head_valid && (!out_valid || out_ready);
  assign pop     = advance && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 4'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= at_last ? 4'd0 : step + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      packet_byte <= byte_sel;
      packet_end  <= at_last && head_job.data_end;
      run_last    <= at_last;
    end
  end

endmodule

@@ rtl/rtp_h264_nal_packetizer.sv @@
// Top level of the RTP H.264 packetiser: configuration registers, front end,
// job queue and back end. Depends on rtph264_pkg and the rtph264_* modules.
//
// One NAL byte is taken per beat on the input channel and RTP packet bytes
// leave one per cycle on the output channel while out_ready holds. A byte that
// continues a packet yields one output byte; a byte that opens a single-NAL
// packet yields 13 and one that opens an FU-A fragment yields 15, because the
// back end serialises the 12-byte RTP header and the two FU bytes before it.
// The queue of QUEUE_DEPTH jobs lets the input run ahead while a header is
// being sent, so over large packets the input sustains close to one byte per
// cycle. The header byte of a fragmented NAL produces no output. Configuration
// writes are accepted on every cycle outside reset and take effect at once;
// writing start_sequence reloads the sequence counter.
module rtp_h264_nal_packetizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  nal_byte,
  input  logic [15:0] nal_length,
  input  logic [31:0] timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  packet_byte,
  output logic        packet_end,
  output logic        run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rtph264_pkg::*;

  logic [6:0]  rtp_pt;
  logic [31:0] stream_source_id;
  logic [13:0] max_payload;
  logic        cfg_write;
  logic        seq_load;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        head_valid;
  job_t        push_job;
  job_t        head_job;

  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready;
  assign seq_load  = cfg_write && (cfg_index == REG_START_SEQUENCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rtp_pt           <= PAYLOAD_TYPE_RESET;
      stream_source_id <= SSRC_RESET;
      max_payload      <= MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PAYLOAD_TYPE: rtp_pt           <= cfg_data[6:0];
        REG_SSRC:         stream_source_id <= cfg_data;
        REG_MAX_PAYLOAD:  max_payload      <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  rtph264_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .nal_byte       (nal_byte),
    .nal_length     (nal_length),
    .timestamp      (timestamp),
    .max_payload    (max_payload),
    .seq_load       (seq_load),
    .seq_load_value (cfg_data[15:0]),
    .queue_full     (queue_full),
    .push           (push),
    .job            (push_job)
  );

  rtph264_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  rtph264_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .rtp_pt           (rtp_pt),
    .stream_source_id (stream_source_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .packet_byte      (packet_byte),
    .packet_end       (packet_end),
    .run_last         (run_last)
  );

endmodule
